// ===== sv/ept_pkg.sv =====
package ept_pkg;

    // input transaction: one pair of raw echo counter readings
    typedef struct packed {
        logic [15:0] raw_count_first;
        logic [15:0] raw_count_second;
    } in_item_t;

    // output transaction: height and status
    typedef struct packed {
        logic [23:0] height_cm_q8;
        logic [1:0]  status;
    } out_item_t;

    // status codes
    localparam logic [1:0] STATUS_OK             = 2'd0;
    localparam logic [1:0] STATUS_FIRST_INVALID  = 2'd1;
    localparam logic [1:0] STATUS_SECOND_INVALID = 2'd2;
    localparam logic [1:0] STATUS_NO_TRIANGLE    = 2'd3;

    // register indexes
    localparam logic [1:0] CFG_COUNT_OFFSET  = 2'd0;
    localparam logic [1:0] CFG_TEMPERATURE_C = 2'd1;
    localparam logic [1:0] CFG_BASELINE_MM   = 2'd2;
    localparam logic [1:0] CFG_TICK_RATE_HZ  = 2'd3;

    // register reset values
    localparam logic [15:0] RST_COUNT_OFFSET  = 16'd59495;
    localparam logic [7:0]  RST_TEMPERATURE_C = 8'd20;
    localparam logic [15:0] RST_BASELINE_MM   = 16'd600;
    localparam logic [23:0] RST_TICK_RATE_HZ  = 24'd172000;

    // sound speed in 0.1 m/s is V10_BASE + V10_SLOPE * temperature
    localparam logic [12:0] V10_BASE    = 13'd3314;
    localparam logic [12:0] V10_SLOPE   = 13'd6;
    // 0.1 m/s times ticks times this over rate gives micrometres (halved path)
    localparam logic [15:0] SPEED_SCALE = 16'd50000;
    localparam logic [9:0]  MM_TO_UM    = 10'd1000;

    // limits and scaling
    localparam logic [29:0] DIST_LIMIT   = 30'h3FFF_FFFF;
    localparam logic [23:0] HEIGHT_MAX   = 24'hFF_FFFF;
    localparam logic [58:0] SAT_Q        = 59'd429496729600000000;
    localparam logic [18:0] CM2_DIVISOR  = 19'd390625;

    // divider and root stage counts
    localparam int DIV1_N = 30;
    localparam int DIV2_N = 59;
    localparam int SQ_N   = 24;

endpackage

// ===== sv/echo_pair_triangulation.sv =====
// throughput: one transaction per cycle; the whole pipeline holds while out_stall is high
// with a result waiting in the output register, set by the single shared stage enable
// the stages include one-bit restoring divider steps (30 and 59) and 24 root steps
// reset: rst_n clears all stage valid bits and loads the registers with their defaults
module echo_pair_triangulation #(
    parameter int COUNT_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  ept_pkg::in_item_t   in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output ept_pkg::out_item_t  out_data,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [23:0]         cfg_data
);

    localparam int CB  = COUNT_BITS;
    localparam int NAW = CB + 28;
    localparam int NBW = CB + 29;
    localparam int NW  = CB + 30;
    localparam int RW1 = (NW > 55) ? NW : 55;
    localparam logic [CB-1:0] PMASK = {CB{1'b1}};

    localparam int D1N = ept_pkg::DIV1_N;
    localparam int D2N = ept_pkg::DIV2_N;
    localparam int SQN = ept_pkg::SQ_N;

    localparam int ST_P   = 0;
    localparam int ST_MUL = 1;
    localparam int ST_RND = 2;
    localparam int ST_D1  = 3;
    localparam int ST_F   = ST_D1 + D1N;
    localparam int ST_UW  = ST_F + 1;
    localparam int ST_PP  = ST_UW + 1;
    localparam int ST_SUM = ST_PP + 1;
    localparam int ST_QC  = ST_SUM + 1;
    localparam int ST_D2  = ST_QC + 1;
    localparam int ST_T   = ST_D2 + D2N;
    localparam int ST_SQ  = ST_T + 1;
    localparam int ST_OUT = ST_SQ + SQN;
    localparam int NST    = ST_OUT + 1;

    typedef struct packed {
        logic       valid;
        logic [1:0] status;
        logic       kill;
        logic       ovf_a;
        logic       ovf_b;
        logic       neg_b;
        logic       sat;
    } ctl_t;

    // configuration registers
    logic [15:0] count_offset_reg;
    logic [7:0]  temperature_c_reg;
    logic [15:0] baseline_mm_reg;
    logic [23:0] tick_rate_hz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_offset_reg  <= ept_pkg::RST_COUNT_OFFSET;
            temperature_c_reg <= ept_pkg::RST_TEMPERATURE_C;
            baseline_mm_reg   <= ept_pkg::RST_BASELINE_MM;
            tick_rate_hz_reg  <= ept_pkg::RST_TICK_RATE_HZ;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ept_pkg::CFG_COUNT_OFFSET:  count_offset_reg  <= cfg_data[15:0];
                ept_pkg::CFG_TEMPERATURE_C: temperature_c_reg <= cfg_data[7:0];
                ept_pkg::CFG_BASELINE_MM:   baseline_mm_reg   <= cfg_data[15:0];
                ept_pkg::CFG_TICK_RATE_HZ:  tick_rate_hz_reg  <= cfg_data;
            endcase
        end
    end

    // derived constants, settled long before an item reaches them
    logic [12:0] v10;
    logic [27:0] v10k_reg;
    logic [23:0] rate_reg;
    logic [25:0] c_reg;
    logic [53:0] d_reg;

    assign v10 = ept_pkg::V10_BASE
               + 13'(ept_pkg::V10_SLOPE * {{5{temperature_c_reg[7]}}, temperature_c_reg});

    always_ff @(posedge clk)
    begin
        v10k_reg <= 28'(28'(v10[11:0]) * 28'(ept_pkg::SPEED_SCALE));
        rate_reg <= (tick_rate_hz_reg == 24'd0) ? 24'd1 : tick_rate_hz_reg;
        c_reg    <= 26'(26'(baseline_mm_reg) * 26'(ept_pkg::MM_TO_UM));
        d_reg    <= {54'(52'(c_reg) * 52'(c_reg))} << 2;
    end

    // control word storage
    ctl_t ctl_reg [NST];
    ctl_t ctl_next [NST];

    // shared stage enable
    logic adv;
    assign adv      = !ctl_reg[ST_OUT].valid || !out_stall;
    assign in_stall = !adv;

    // pipeline storage
    logic [CB-1:0]  p1_reg, p2_reg;
    logic [NAW-1:0] na_reg;
    logic [NBW-1:0] nb_reg;
    logic [RW1-1:0] ra_reg, rb_reg;
    logic [RW1-1:0] rema_reg [D1N], remb_reg [D1N];
    logic [29:0]    qa_reg [D1N], qb_reg [D1N];
    logic [31:0]    m_reg [4];
    logic [63:0]    u_reg, w_reg;
    logic [63:0]    pp_ll_reg, pp_lh_reg, pp_hl_reg, pp_hh_reg;
    logic [127:0]   prod_reg;
    logic [127:0]   rq_reg;
    logic [127:0]   rem2_reg [D2N];
    logic [58:0]    q2_reg [D2N];
    logic [66:0]    num_reg;
    logic [66:0]    sqx_reg [SQN];
    logic [42:0]    sqd_reg [SQN];
    logic [23:0]    sqr_reg [SQN];
    ept_pkg::out_item_t out_reg;

    logic [RW1-1:0] rema_next [D1N], remb_next [D1N];
    logic [29:0]    qa_next [D1N], qb_next [D1N];
    logic [127:0]   rem2_next [D2N];
    logic [58:0]    q2_next [D2N];
    logic [66:0]    sqx_next [SQN];
    logic [42:0]    sqd_next [SQN];
    logic [23:0]    sqr_next [SQN];

    // front end: offset removal and speed products
    logic [CB+15:0]    p1_wide, p2_wide;
    logic signed [CB+1:0] diff;
    logic [CB:0]       mag_d;
    logic [RW1-1:0]    ra_next, rb_next;
    logic              ovf_a_next, ovf_b_next;

    assign p1_wide = {{CB{1'b0}}, in_data.raw_count_first}  - {{CB{1'b0}}, count_offset_reg};
    assign p2_wide = {{CB{1'b0}}, in_data.raw_count_second} - {{CB{1'b0}}, count_offset_reg};
    assign diff    = $signed({p2_reg, 2'b0} >> 1) - $signed({2'b0, p1_reg});
    assign mag_d   = diff[CB+1] ? (CB+1)'(-diff) : diff[CB:0];
    assign ra_next = RW1'(na_reg) + RW1'(rate_reg[23:1]);
    assign rb_next = RW1'(nb_reg) + RW1'(rate_reg[23:1]);
    assign ovf_a_next = ra_next >= (RW1'(rate_reg) << D1N);
    assign ovf_b_next = rb_next >= (RW1'(rate_reg) << D1N);

    // triangle factors
    logic [29:0]         a_u, b_u;
    logic signed [33:0]  av, bv, cv;
    logic signed [33:0]  f [4];
    logic                f_zero, f_neg;

    always_comb
    begin
        a_u = ctl_reg[ST_F - 1].ovf_a ? ept_pkg::DIST_LIMIT : qa_reg[D1N - 1];
        b_u = ctl_reg[ST_F - 1].ovf_b ? ept_pkg::DIST_LIMIT : qb_reg[D1N - 1];
        av  = $signed(34'(a_u));
        bv  = ctl_reg[ST_F - 1].neg_b ? -$signed(34'(b_u)) : $signed(34'(b_u));
        cv  = $signed(34'(c_reg));
        f[0] = av + bv + cv;
        f[1] = bv + cv - av;
        f[2] = av + cv - bv;
        f[3] = av + bv - cv;
        f_zero = (f[0] == 34'sd0) || (f[1] == 34'sd0) || (f[2] == 34'sd0) || (f[3] == 34'sd0);
        f_neg  = f[0][33] ^ f[1][33] ^ f[2][33] ^ f[3][33];
    end

    // divider and root steps
    // the root takes the largest h with h*h*390625 <= 256*Q, which equals
    // the root of the floored quotient, so no constant division is needed
    always_comb
    begin
        logic [RW1-1:0] ra_in, rb_in, ta;
        logic [127:0]   r2_in, t2;
        logic [66:0]    x_in;
        logic [42:0]    hd_in;
        logic [23:0]    r_in;
        logic [67:0]    trial;
        logic [29:0]    qa_in, qb_in;
        logic [58:0]    q2_in;
        for (int j = 0; j < D1N; j++)
        begin
            ra_in = (j == 0) ? (ctl_reg[ST_RND].ovf_a ? '0 : ra_reg) : rema_reg[j - 1];
            rb_in = (j == 0) ? (ctl_reg[ST_RND].ovf_b ? '0 : rb_reg) : remb_reg[j - 1];
            qa_in = (j == 0) ? '0 : qa_reg[j - 1];
            qb_in = (j == 0) ? '0 : qb_reg[j - 1];
            ta = RW1'(rate_reg) << (D1N - 1 - j);
            rema_next[j] = (ra_in >= ta) ? ra_in - ta : ra_in;
            remb_next[j] = (rb_in >= ta) ? rb_in - ta : rb_in;
            qa_next[j]   = qa_in | ((ra_in >= ta) ? (30'd1 << (D1N - 1 - j)) : 30'd0);
            qb_next[j]   = qb_in | ((rb_in >= ta) ? (30'd1 << (D1N - 1 - j)) : 30'd0);
        end
        for (int j = 0; j < D2N; j++)
        begin
            r2_in = (j == 0) ? rq_reg : rem2_reg[j - 1];
            q2_in = (j == 0) ? '0 : q2_reg[j - 1];
            t2 = 128'(d_reg) << (D2N - 1 - j);
            rem2_next[j] = (r2_in >= t2) ? r2_in - t2 : r2_in;
            q2_next[j]   = q2_in | ((r2_in >= t2) ? (59'd1 << (D2N - 1 - j)) : 59'd0);
        end
        for (int j = 0; j < SQN; j++)
        begin
            x_in  = (j == 0) ? num_reg : sqx_reg[j - 1];
            hd_in = (j == 0) ? '0 : sqd_reg[j - 1];
            r_in  = (j == 0) ? '0 : sqr_reg[j - 1];
            // growth of h*h*divisor when bit k is set: 2*h*divisor*2^k + divisor*4^k
            trial = (68'(hd_in) << (SQN - j))
                  + (68'(ept_pkg::CM2_DIVISOR) << (2 * (SQN - 1 - j)));
            if (68'(x_in) >= trial)
            begin
                sqx_next[j] = x_in - trial[66:0];
                sqd_next[j] = hd_in + (43'(ept_pkg::CM2_DIVISOR) << (SQN - 1 - j));
                sqr_next[j] = r_in | (24'd1 << (SQN - 1 - j));
            end
            else
            begin
                sqx_next[j] = x_in;
                sqd_next[j] = hd_in;
                sqr_next[j] = r_in;
            end
        end
    end

    // control word per stage
    always_comb
    begin
        ctl_next[0].valid  = in_valid;
        ctl_next[0].kill   = 1'b1;
        ctl_next[0].ovf_a  = 1'b0;
        ctl_next[0].ovf_b  = 1'b0;
        ctl_next[0].neg_b  = 1'b0;
        ctl_next[0].sat    = 1'b0;
        priority if (p1_wide[CB-1:0] == PMASK)
            ctl_next[0].status = ept_pkg::STATUS_FIRST_INVALID;
        else if (p2_wide[CB-1:0] == PMASK)
            ctl_next[0].status = ept_pkg::STATUS_SECOND_INVALID;
        else if (baseline_mm_reg == 16'd0)
            ctl_next[0].status = ept_pkg::STATUS_NO_TRIANGLE;
        else
        begin
            ctl_next[0].status = ept_pkg::STATUS_OK;
            ctl_next[0].kill   = 1'b0;
        end
        for (int k = 1; k < NST; k++)
        begin
            ctl_next[k] = ctl_reg[k - 1];
        end
        ctl_next[ST_MUL].neg_b = diff[CB+1];
        ctl_next[ST_RND].ovf_a = ovf_a_next;
        ctl_next[ST_RND].ovf_b = ovf_b_next;
        if (!ctl_reg[ST_F - 1].kill)
        begin
            if (f_zero)
            begin
                ctl_next[ST_F].kill = 1'b1;
            end
            else if (f_neg)
            begin
                ctl_next[ST_F].kill   = 1'b1;
                ctl_next[ST_F].status = ept_pkg::STATUS_NO_TRIANGLE;
            end
        end
        ctl_next[ST_QC].sat = prod_reg >= (128'(d_reg) << D2N);
        ctl_next[ST_T].sat  = ctl_reg[ST_T - 1].sat || (q2_reg[D2N - 1] >= ept_pkg::SAT_Q);
    end

    // control pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NST; k++)
            begin
                ctl_reg[k] <= '0;
            end
        end
        else if (adv)
        begin
            for (int k = 0; k < NST; k++)
            begin
                ctl_reg[k] <= ctl_next[k];
            end
        end
    end

    // datapath pipeline
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_reg <= p1_wide[CB-1:0];
            p2_reg <= p2_wide[CB-1:0];
            na_reg <= NAW'(v10k_reg) * NAW'(p1_reg);
            nb_reg <= NBW'(v10k_reg) * NBW'(mag_d);
            ra_reg <= ra_next;
            rb_reg <= rb_next;
            for (int j = 0; j < D1N; j++)
            begin
                rema_reg[j] <= rema_next[j];
                remb_reg[j] <= remb_next[j];
                qa_reg[j]   <= qa_next[j];
                qb_reg[j]   <= qb_next[j];
            end
            for (int i = 0; i < 4; i++)
            begin
                m_reg[i] <= f[i][33] ? 32'(-f[i]) : f[i][31:0];
            end
            u_reg     <= 64'(m_reg[0]) * 64'(m_reg[3]);
            w_reg     <= 64'(m_reg[1]) * 64'(m_reg[2]);
            pp_ll_reg <= 64'(u_reg[31:0])  * 64'(w_reg[31:0]);
            pp_lh_reg <= 64'(u_reg[31:0])  * 64'(w_reg[63:32]);
            pp_hl_reg <= 64'(u_reg[63:32]) * 64'(w_reg[31:0]);
            pp_hh_reg <= 64'(u_reg[63:32]) * 64'(w_reg[63:32]);
            prod_reg  <= 128'(pp_ll_reg) + (128'(pp_lh_reg) << 32)
                       + (128'(pp_hl_reg) << 32) + {pp_hh_reg, 64'd0};
            rq_reg    <= ctl_next[ST_QC].sat ? '0 : prod_reg;
            for (int j = 0; j < D2N; j++)
            begin
                rem2_reg[j] <= rem2_next[j];
                q2_reg[j]   <= q2_next[j];
            end
            num_reg <= {q2_reg[D2N - 1], 8'd0};
            for (int j = 0; j < SQN; j++)
            begin
                sqx_reg[j] <= sqx_next[j];
                sqd_reg[j] <= sqd_next[j];
                sqr_reg[j] <= sqr_next[j];
            end
            out_reg.status <= ctl_reg[ST_OUT - 1].status;
            if (ctl_reg[ST_OUT - 1].kill)
                out_reg.height_cm_q8 <= '0;
            else if (ctl_reg[ST_OUT - 1].sat)
                out_reg.height_cm_q8 <= ept_pkg::HEIGHT_MAX;
            else
                out_reg.height_cm_q8 <= sqr_reg[SQN - 1];
        end
    end

    assign out_valid = ctl_reg[ST_OUT].valid;
    assign out_data  = out_reg;

    // a rejected or degenerate item carries no height
    a_status_height: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status != ept_pkg::STATUS_OK) |-> out_data.height_cm_q8 == '0)
        else $error("nonzero status with nonzero height");

    // input stall only while a result waits on a stalled output
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("input stall without output backpressure");

    // a new result only comes out of the stage before it
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(ctl_reg[ST_OUT - 1].valid))
        else $error("result appeared without a transaction behind it");

    // invalid sensor status is set only at the front and never changes later
    a_status_keep: assert property (@(posedge clk) disable iff (!rst_n)
        $past(adv) && $past(ctl_reg[ST_F - 1].valid)
        && ($past(ctl_reg[ST_F - 1].status) != ept_pkg::STATUS_OK)
        |-> ctl_reg[ST_F].status == $past(ctl_reg[ST_F - 1].status))
        else $error("early status overwritten");

endmodule
